>>> design/msrc_pkg.sv
`timescale 1ns / 1ps
package msrc_pkg;

  // Fixed design constants
  localparam int unsigned CLOCK_HZ   = 64000000;
  localparam int unsigned POLE_COUNT = 4;

  // Divider width covers 2*CLOCK_HZ*1000 + D and 2*D over the full parameter range
  localparam int unsigned DIV_W   = 41;
  localparam int unsigned DCNT_W  = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] NUM2    = DIV_W'(64'd2 * 64'(CLOCK_HZ) * 64'd1000);
  localparam logic [DIV_W-1:0] K_MOTOR = DIV_W'(POLE_COUNT * 6);
  localparam logic [DIV_W-1:0] K_LED   = DIV_W'(6);
  // ceil(2^40 / 50000): floor(x * DUTY_RECIP / 2^40) == floor(x / 50000) for x < 2^24
  localparam logic [24:0] DUTY_RECIP = 25'd21990233;

  // Speed and timing constants (speed in 0.001 units)
  localparam logic [13:0] MIN_MILLI  = 14'd1000;
  localparam logic [13:0] MAX_MILLI  = 14'd10000;
  localparam logic [13:0] INIT_MILLI = 14'd100;
  localparam logic [15:0] STEP_MILLI = 16'd200;
  localparam logic [13:0] DEC_MILLI  = 14'd5;
  localparam logic [31:0] STEP_MS    = 32'd5;
  localparam logic [31:0] BLINK_MS   = 32'd1000;
  localparam logic [9:0]  DUTY_MAX   = 10'd1000;
  localparam logic [9:0]  DUTY_RST   = 10'd700;

  typedef enum logic [2:0] {
    MODE_STOP     = 3'd0,
    MODE_ACCEL    = 3'd1,
    MODE_DECEL    = 3'd2,
    MODE_RUN      = 3'd3,
    MODE_STOPPING = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_RIGHT = 2'd1,
    BTN_LEFT  = 2'd2,
    BTN_STOP  = 2'd3
  } btn_e;

  typedef enum logic [1:0] {
    DRV_NONE  = 2'd0,
    DRV_START = 2'd1,
    DRV_STOP  = 2'd2
  } drive_e;

  // Register addresses (word index)
  localparam logic [1:0] REG_SUPPLY = 2'd0;
  localparam logic [1:0] REG_MPSC   = 2'd1;
  localparam logic [1:0] REG_LPSC   = 2'd2;

  typedef struct packed {
    logic capture;
    logic step;
    logic mul1;
    logic mul2;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } sts_t;

  // Base duty by supply step; accel scales by 1.3, others use plain base
  function automatic logic [9:0] duty_base(logic [2:0] lvl, logic accel);
    logic [9:0] b;
    case (lvl)
      3'd0:    b = 10'd0;
      3'd1:    b = accel ? 10'd780 : 10'd600;
      3'd2:    b = accel ? 10'd663 : 10'd510;
      3'd3:    b = accel ? 10'd546 : 10'd420;
      default: b = accel ? 10'd429 : 10'd330;
    endcase
    return b;
  endfunction

  // Saturate quotient to 32 bits, then reload = q - 1 (wraps)
  function automatic logic [31:0] reload_of(logic [DIV_W-1:0] q);
    logic [31:0] q32;
    q32 = (|q[DIV_W-1:32]) ? 32'hFFFF_FFFF : q[31:0];
    return q32 - 32'd1;
  endfunction

endpackage

>>> design/msrc_div.sv
`timescale 1ns / 1ps
module msrc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [msrc_pkg::DIV_W-1:0] num_i,
  input  logic [msrc_pkg::DIV_W-1:0] den_i,
  output logic                      busy_o,
  output logic [msrc_pkg::DIV_W-1:0] quo_o
);
  import msrc_pkg::*;

  logic [DIV_W:0]    rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  den_q, den_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;

  // One restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    shifted = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = DCNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = diff;
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

>>> design/msrc_ctrl.sv
`timescale 1ns / 1ps
module msrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  msrc_pkg::sts_t  sts_i,
  output msrc_pkg::cmd_t  cmd_o
);
  import msrc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_STEP  = 7'b0000010,
    S_MUL1  = 7'b0000100,
    S_MUL2  = 7'b0001000,
    S_DIVGO = 7'b0010000,
    S_DIVW  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer: step update, two multiply stages, parallel divide, result hand-off
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_STEP;
      S_STEP:  state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIVW;
      S_DIVW:  if (!sts_i.div_busy) state_d = S_FIN;
      S_FIN:   if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.step      = (state_q == S_STEP);
    cmd_o.mul1      = (state_q == S_MUL1);
    cmd_o.mul2      = (state_q == S_MUL2);
    cmd_o.div_start = (state_q == S_DIVGO);
    cmd_o.finish    = (state_q == S_FIN) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_to_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_STEP)
    else $error("accepted item did not start a step");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !sts_i.div_busy)
    else $error("divider busy while idle");

  a_divgo_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVGO |=> sts_i.div_busy)
    else $error("divider did not start");

endmodule

>>> design/msrc_dp.sv
`timescale 1ns / 1ps
module msrc_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  msrc_pkg::cmd_t  cmd_i,
  output msrc_pkg::sts_t  sts_o,
  input  logic [39:0]     in_data_i,
  input  logic [2:0]      supply_i,
  input  logic [15:0]     mpsc_i,
  input  logic [15:0]     lpsc_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [119:0]    out_data_o
);
  import msrc_pkg::*;

  // Latched input item
  logic        lpin_q, rpin_q, spin_q;
  logic [31:0] now_q;

  // Architectural state
  mode_e       mode_q, mode_d, last_q, last_d;
  logic        dir_q, dir_d;
  logic [13:0] speed_q, speed_d;
  logic [15:0] tgt_q, tgt_d;
  logic [31:0] wait_q, wait_d;
  logic [9:0]  duty_q;

  // Per-item results held until hand-off
  logic        load_q, load_d;
  drive_e      drive_q, drive_d;
  logic        al_q, al_d;
  logic [12:0] at_q, at_d;
  logic [9:0]  ap_q, ap_d;
  logic        blink_q, blink_d;
  logic        dupd_q, dupd_d;
  logic [9:0]  base_q;
  logic [13:0] dspd_q;

  // Multiply stages
  logic [30:0]      pm_q, pl_q;
  logic [23:0]      dp_q;
  logic [DIV_W-1:0] dm_q, dl_q;
  logic [48:0]      duty_prod;
  logic [8:0]       dq_q;

  // Reload divisions and duty scaling
  logic [DIV_W-1:0] qm, ql;
  logic             bm, bl;
  logic [10:0]      duty_sum;
  logic [9:0]       duty_new;

  // Button decode
  logic       lp, rp, sp;
  logic [1:0] npress;
  btn_e       btn;
  logic       blocked;
  logic [31:0] at_prod;
  logic [16:0] tgt_add;

  assign lp     = ~lpin_q;
  assign rp     = ~rpin_q;
  assign sp     = ~spin_q;
  assign npress = 2'(lp) + 2'(rp) + 2'(sp);
  always_comb begin
    if (npress != 2'd1) btn = BTN_NONE;
    else if (lp)        btn = BTN_LEFT;
    else if (rp)        btn = BTN_RIGHT;
    else                btn = BTN_STOP;
  end

  // floor(speed*4/5) by reciprocal multiply
  assign at_prod = 32'({speed_q, 2'b00}) * 32'd52429;
  assign tgt_add = {1'b0, tgt_q} + {1'b0, STEP_MILLI};
  assign blocked = (wait_q > now_q) && (mode_q == MODE_ACCEL || mode_q == MODE_DECEL);

  // Mode step for one tick
  always_comb begin
    mode_d  = mode_q;
    last_d  = last_q;
    dir_d   = dir_q;
    speed_d = speed_q;
    tgt_d   = tgt_q;
    wait_d  = wait_q;
    load_d  = 1'b0;
    drive_d = DRV_NONE;
    al_d    = 1'b0;
    at_d    = '0;
    ap_d    = '0;
    blink_d = 1'b0;
    dupd_d  = 1'b0;
    if (btn == BTN_STOP) begin
      mode_d = MODE_STOPPING;
      tgt_d  = '0;
    end
    if (!blocked) begin
      case (mode_q)
        MODE_STOP: begin
          if (mode_q != last_q) begin
            al_d    = 1'b1;
            at_d    = at_prod[30:18];
            ap_d    = DUTY_MAX;
            speed_d = '0;
            drive_d = DRV_STOP;
            wait_d  = now_q + BLINK_MS;
          end
          if (btn == BTN_LEFT || btn == BTN_RIGHT) begin
            mode_d = MODE_ACCEL;
            tgt_d  = 16'(MIN_MILLI);
            dir_d  = (btn == BTN_LEFT);
          end
          if (now_q > wait_d) begin
            blink_d = 1'b1;
            wait_d  = wait_d + BLINK_MS;
          end
        end
        MODE_RUN: begin
          if (btn == BTN_LEFT || btn == BTN_RIGHT) begin
            if ((btn == BTN_RIGHT) == (dir_q == 1'b0)) begin
              mode_d = MODE_ACCEL;
              tgt_d  = tgt_add[16] ? 16'hFFFF : tgt_add[15:0];
            end else begin
              mode_d = MODE_DECEL;
              tgt_d  = (tgt_q > STEP_MILLI) ? tgt_q - STEP_MILLI : 16'd0;
            end
          end
          dupd_d = 1'b1;
        end
        MODE_ACCEL: begin
          dupd_d = 1'b1;
          if (tgt_d > 16'(MAX_MILLI)) begin
            tgt_d = 16'(MAX_MILLI);
          end else begin
            if (last_q == MODE_STOP) begin
              al_d    = 1'b1;
              at_d    = 13'd300;
              ap_d    = 10'd300;
              speed_d = INIT_MILLI;
              drive_d = DRV_START;
              load_d  = 1'b1;
            end
            if (16'(speed_d) < tgt_d) begin
              speed_d = speed_d + 14'd1;
              load_d  = 1'b1;
            end else begin
              tgt_d  = 16'(speed_d);
              mode_d = MODE_RUN;
            end
            wait_d = now_q + STEP_MS;
          end
        end
        MODE_DECEL, MODE_STOPPING: begin
          if (speed_q < MIN_MILLI) begin
            if (mode_q == MODE_DECEL) begin
              speed_d = INIT_MILLI;
              tgt_d   = 16'(MIN_MILLI);
              dir_d   = ~dir_q;
              mode_d  = MODE_ACCEL;
            end else begin
              mode_d = MODE_STOP;
            end
          end else begin
            if (16'(speed_q) > tgt_d) begin
              speed_d = (speed_q > DEC_MILLI) ? speed_q - DEC_MILLI : 14'd0;
              load_d  = 1'b1;
            end else begin
              tgt_d  = 16'(speed_q);
              mode_d = MODE_RUN;
            end
            wait_d = now_q + STEP_MS;
          end
        end
        default: ;
      endcase
      last_d = mode_q;
    end
  end

  // Control-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_STOP;
      last_q  <= MODE_STOP;
      dir_q   <= 1'b0;
      speed_q <= '0;
      tgt_q   <= '0;
      wait_q  <= '0;
      duty_q  <= DUTY_RST;
    end else begin
      if (cmd_i.step) begin
        mode_q  <= mode_d;
        last_q  <= last_d;
        dir_q   <= dir_d;
        speed_q <= speed_d;
        tgt_q   <= tgt_d;
        wait_q  <= wait_d;
      end
      if (cmd_i.finish && dupd_q) begin
        duty_q <= duty_new;
      end
    end
  end

  // floor(base*speed/50000) by reciprocal multiply
  assign duty_prod = 49'(dp_q) * 49'(DUTY_RECIP);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lpin_q <= in_data_i[0];
      rpin_q <= in_data_i[1];
      spin_q <= in_data_i[2];
      now_q  <= in_data_i[34:3];
    end
    if (cmd_i.step) begin
      load_q  <= load_d;
      drive_q <= drive_d;
      al_q    <= al_d;
      at_q    <= at_d;
      ap_q    <= ap_d;
      blink_q <= blink_d;
      dupd_q  <= dupd_d;
      base_q  <= duty_base(supply_i, mode_q == MODE_ACCEL);
      dspd_q  <= speed_q;
    end
    if (cmd_i.mul1) begin
      pm_q <= 31'({1'b0, mpsc_i} + 17'd1) * 31'(speed_q);
      pl_q <= 31'({1'b0, lpsc_i} + 17'd1) * 31'(speed_q);
      dp_q <= 24'(base_q) * 24'(dspd_q);
    end
    if (cmd_i.mul2) begin
      dm_q <= DIV_W'(pm_q) * K_MOTOR;
      dl_q <= DIV_W'(pl_q) * K_LED;
      dq_q <= duty_prod[48:40];
    end
  end

  // Rounded reload divisions
  msrc_div u_div_motor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (NUM2 + dm_q),
    .den_i  ({dm_q[DIV_W-2:0], 1'b0}),
    .busy_o (bm),
    .quo_o  (qm)
  );

  msrc_div u_div_led (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (NUM2 + dl_q),
    .den_i  ({dl_q[DIV_W-2:0], 1'b0}),
    .busy_o (bl),
    .quo_o  (ql)
  );

  assign duty_sum = {1'b0, base_q} + {2'b00, dq_q};
  assign duty_new = (duty_sum > 11'(DUTY_MAX)) ? DUTY_MAX : duty_sum[9:0];

  // Output register
  logic         ovalid_q;
  logic [119:0] odata_q;
  logic [31:0]  mrel, lrel;

  assign mrel = load_q ? reload_of(qm) : 32'd0;
  assign lrel = load_q ? reload_of(ql) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      odata_q <= {blink_q, ap_q, at_q, al_q, drive_q, load_q, lrel, mrel,
                  (dupd_q ? duty_new : duty_q), speed_q, dir_q, mode_q};
    end
  end

  // Status: {div_busy, out_free}
  assign sts_o       = {bm | bl, !ovalid_q || out_ready_i};
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  a_reload_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && load_q |-> speed_q != 14'd0)
    else $error("reload produced for zero speed");

  a_dividers_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bm == bl)
    else $error("dividers out of step");

  a_align_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (drive_q != DRV_NONE) == al_q)
    else $error("drive event without align request");

endmodule

>>> design/motor_speed_ramp_controller_core.sv
`timescale 1ns / 1ps
// Motor speed ramp controller.
// Input stream (s_axis): one control tick per item carrying three active-low
// button pins and the millisecond time. Output stream (m_axis): one result per
// tick with mode, direction, speed, duty, timer reloads, drive/align events
// and the stop-mode blink.
// Configuration through the APB port: supply_level at 0x0, motor_prescaler at
// 0x4, led_prescaler at 0x8; pready is always high, reads return the value.
// Processing: an accepted item goes through step update, two multiply stages
// with the duty scaling by reciprocal multiply, divider start, the two
// parallel restoring dividers for the rounded reloads, done check and
// hand-off. One item is in work at a time, so a new item is taken only
// after the last one has been handed to the output register.
// The result sits in an output register; a stalled receiver holds the block
// in its final state until the register frees, and s_axis_tready stays low.
// Reset puts the block in stop mode, speed 0, direction right, duty 700,
// supply_level 3 and both prescalers 0.
module motor_speed_ramp_controller_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [0] left_btn_n, [1] right_btn_n, [2] stop_btn_n, [34:3] now_ms, [39:35] zero
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] mode, [3] direction, [17:4] speed_milli, [27:18] duty,
  // [59:28] motor_reload, [91:60] led_reload, [92] reload_load,
  // [94:93] drive_event, [95] align_request, [108:96] align_time_ms,
  // [118:109] align_power, [119] blink
  output logic [119:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import msrc_pkg::*;

  logic [2:0]  supply_q;
  logic [15:0] mpsc_q, lpsc_q;
  logic        wr;
  cmd_t        cmd;
  sts_t        sts;

  // Configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= 3'd3;
      mpsc_q   <= '0;
      lpsc_q   <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_SUPPLY: supply_q <= pwdata[2:0];
        REG_MPSC:   mpsc_q   <= pwdata[15:0];
        REG_LPSC:   lpsc_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SUPPLY: prdata = {29'd0, supply_q};
      REG_MPSC:   prdata = {16'd0, mpsc_q};
      REG_LPSC:   prdata = {16'd0, lpsc_q};
      default:    prdata = '0;
    endcase
  end

  msrc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  msrc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .supply_i   (supply_q),
    .mpsc_i     (mpsc_q),
    .lpsc_i     (lpsc_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import msrc_pkg::*;

  // Result item as it sits on m_axis_tdata, top field first
  typedef struct packed {
    logic        blink;
    logic [9:0]  align_power;
    logic [12:0] align_time_ms;
    logic        align_request;
    logic [1:0]  drive_event;
    logic        reload_load;
    logic [31:0] led_reload;
    logic [31:0] motor_reload;
    logic [9:0]  duty;
    logic [13:0] speed_milli;
    logic        direction;
    logic [2:0]  mode;
  } tick_out_t;

  typedef struct {
    logic        left_n;
    logic        right_n;
    logic        stop_n;
    logic [31:0] now_ms;
    logic        typed;
    tick_out_t   typed_out;
  } tick_row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  motor_speed_ramp_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow of the block's registers and state
  logic [2:0]  cfg_supply;
  logic [15:0] cfg_mpsc;
  logic [15:0] cfg_lpsc;
  mode_e       st_mode;
  mode_e       st_last;
  logic        st_dir;
  int unsigned st_speed;
  int unsigned st_target;
  logic [31:0] st_deadline;
  int unsigned st_duty;

  tick_out_t   pending_ticks[$];
  int          fail_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  int          quiet_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Duty scaling by supply step and mode
  function automatic int unsigned ramp_duty(mode_e m, logic [2:0] lvl, int unsigned s);
    longint unsigned b;
    case (lvl > 3'd4 ? 3'd4 : lvl)
      3'd0: b = 0;
      3'd1: b = 600;
      3'd2: b = 510;
      3'd3: b = 420;
      default: b = 330;
    endcase
    if (m == MODE_ACCEL) b = b * 13 / 10;
    else if (m == MODE_DECEL) b = b * 4 / 5;
    b = b * (50000 + longint'(s)) / 50000;
    return (b > 1000) ? 1000 : int'(b);
  endfunction

  // Rounded timer reload, saturated quotient minus one
  function automatic logic [31:0] ramp_reload(int unsigned s, logic [15:0] psc,
                                              longint unsigned k);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    if (s == 0) begin
      q = 64'hFFFF_FFFF;
    end else begin
      n = 64'd64000000 * 64'd1000;
      d = (longint'(psc) + 1) * longint'(s) * k;
      q = (2 * n + d) / (2 * d);
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    end
    return q[31:0] - 32'd1;
  endfunction

  // Advances the shadow state by one tick and returns the result item
  function automatic tick_out_t ramp_tick(logic ln, logic rn, logic sn, logic [31:0] now);
    tick_out_t o;
    btn_e      btn;
    mode_e     cur;
    mode_e     nxt;
    logic      l, r, s;
    logic      faster;
    o   = '0;
    l   = ~ln;
    r   = ~rn;
    s   = ~sn;
    btn = BTN_NONE;
    cur = st_mode;
    nxt = st_mode;
    if (int'(l) + int'(r) + int'(s) == 1)
      btn = l ? BTN_LEFT : (r ? BTN_RIGHT : BTN_STOP);
    if (btn == BTN_STOP) begin
      nxt = MODE_STOPPING;
      st_target = 0;
    end
    if (!(st_deadline > now && (cur == MODE_ACCEL || cur == MODE_DECEL))) begin
      case (cur)
        MODE_STOP: begin
          if (cur != st_last) begin
            o.align_request = 1'b1;
            o.align_time_ms = 13'(st_speed * 4 / 5);
            o.align_power   = 10'd1000;
            st_speed        = 0;
            o.drive_event   = DRV_STOP;
            st_deadline     = now + 32'd1000;
          end
          if (btn == BTN_LEFT || btn == BTN_RIGHT) begin
            nxt       = MODE_ACCEL;
            st_target = 1000;
            st_dir    = (btn == BTN_LEFT);
          end
          if (now > st_deadline) begin
            o.blink     = 1'b1;
            st_deadline = st_deadline + 32'd1000;
          end
        end
        MODE_RUN: begin
          if (btn == BTN_LEFT || btn == BTN_RIGHT) begin
            faster = ((btn == BTN_RIGHT) == (st_dir == 1'b0));
            if (faster) begin
              nxt       = MODE_ACCEL;
              st_target = (st_target + 200 > 65535) ? 65535 : st_target + 200;
            end else begin
              nxt       = MODE_DECEL;
              st_target = (st_target > 200) ? st_target - 200 : 0;
            end
          end
          st_duty = ramp_duty(cur, cfg_supply, st_speed);
        end
        MODE_ACCEL: begin
          st_duty = ramp_duty(cur, cfg_supply, st_speed);
          if (st_target > 10000) begin
            st_target = 10000;
          end else begin
            if (st_last == MODE_STOP) begin
              o.align_request = 1'b1;
              o.align_time_ms = 13'd300;
              o.align_power   = 10'd300;
              st_speed        = 100;
              o.drive_event   = DRV_START;
              o.reload_load   = 1'b1;
            end
            if (st_speed < st_target) begin
              st_speed      = st_speed + 1;
              o.reload_load = 1'b1;
            end else begin
              st_target = st_speed;
              nxt       = MODE_RUN;
            end
            st_deadline = now + 32'd5;
          end
        end
        MODE_DECEL, MODE_STOPPING: begin
          if (st_speed < 1000) begin
            if (cur == MODE_DECEL) begin
              st_speed  = 100;
              st_target = 1000;
              st_dir    = ~st_dir;
              nxt       = MODE_ACCEL;
            end else begin
              nxt = MODE_STOP;
            end
          end else begin
            if (st_speed > st_target) begin
              st_speed      = (st_speed > 5) ? st_speed - 5 : 0;
              o.reload_load = 1'b1;
            end else begin
              st_target = st_speed;
              nxt       = MODE_RUN;
            end
            st_deadline = now + 32'd5;
          end
        end
        default: ;
      endcase
      st_last = cur;
    end
    st_mode = nxt;
    if (o.reload_load) begin
      o.motor_reload = ramp_reload(st_speed, cfg_mpsc, 64'd24);
      o.led_reload   = ramp_reload(st_speed, cfg_lpsc, 64'd6);
    end
    o.mode        = st_mode;
    o.direction   = st_dir;
    o.speed_milli = 14'(st_speed);
    o.duty        = 10'(st_duty);
    return o;
  endfunction

  // Offers one tick and waits until it is taken; tvalid stays high afterwards
  task automatic send_tick(logic ln, logic rn, logic sn, logic [31:0] now,
                           logic typed, tick_out_t typed_out);
    tick_out_t exp_out;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, now, sn, rn, ln};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_out = ramp_tick(ln, rn, sn, now);
    pending_ticks.push_back(typed ? typed_out : exp_out);
  endtask

  // Waits until all results are back and the block has gone quiet
  task automatic drain_ticks();
    s_axis_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      4'd0: cfg_supply = val[2:0];
      4'd4: cfg_mpsc   = val[15:0];
      default: cfg_lpsc = val[15:0];
    endcase
  endtask

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker and watchdog
  always @(posedge clk_i) begin
    tick_out_t got;
    tick_out_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_ticks.size() == 0) begin
        $error("result with no tick outstanding");
        fail_cnt++;
      end else begin
        want = pending_ticks.pop_front();
        if (got.mode != want.mode)
          begin $error("mode exp %0d got %0d", want.mode, got.mode); fail_cnt++; end
        if (got.direction != want.direction)
          begin $error("direction exp %0d got %0d", want.direction, got.direction); fail_cnt++; end
        if (got.speed_milli != want.speed_milli)
          begin $error("speed_milli exp %0d got %0d", want.speed_milli, got.speed_milli);
            fail_cnt++; end
        if (got.duty != want.duty)
          begin $error("duty exp %0d got %0d", want.duty, got.duty); fail_cnt++; end
        if (got.motor_reload != want.motor_reload)
          begin $error("motor_reload exp %0h got %0h", want.motor_reload, got.motor_reload);
            fail_cnt++; end
        if (got.led_reload != want.led_reload)
          begin $error("led_reload exp %0h got %0h", want.led_reload, got.led_reload);
            fail_cnt++; end
        if (got.reload_load != want.reload_load)
          begin $error("reload_load exp %0d got %0d", want.reload_load, got.reload_load);
            fail_cnt++; end
        if (got.drive_event != want.drive_event)
          begin $error("drive_event exp %0d got %0d", want.drive_event, got.drive_event);
            fail_cnt++; end
        if (got.align_request != want.align_request)
          begin $error("align_request exp %0d got %0d", want.align_request,
            got.align_request); fail_cnt++; end
        if (got.align_time_ms != want.align_time_ms)
          begin $error("align_time_ms exp %0d got %0d", want.align_time_ms,
            got.align_time_ms); fail_cnt++; end
        if (got.align_power != want.align_power)
          begin $error("align_power exp %0d got %0d", want.align_power, got.align_power);
            fail_cnt++; end
        if (got.blink != want.blink)
          begin $error("blink exp %0d got %0d", want.blink, got.blink); fail_cnt++; end
      end
    end
  end

  // Stimulus
  initial begin
    tick_row_t   rows[$];
    tick_row_t   row;
    tick_out_t   idle_out;
    logic [31:0] tnow;
    logic [2:0]  sup_set[6];
    logic [15:0] mpsc_set[6];
    logic [15:0] lpsc_set[6];
    logic        ln, rn, sn;
    int          pick;
    int          item_idx;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    fail_cnt = 0; quiet_cycles = 0; hold_req = 1'b0;
    send_idle_pct = 24; recv_idle_pct = 78;
    cfg_supply = 3'd3; cfg_mpsc = '0; cfg_lpsc = '0;
    st_mode = MODE_STOP; st_last = MODE_STOP; st_dir = 1'b0; st_speed = 0;
    st_target = 0; st_deadline = '0; st_duty = 700;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, blink, starts, stop during wait, multi-press, extremes
    idle_out      = '0;
    idle_out.duty = 10'd700;
    rows.push_back('{1, 1, 1, 32'd0, 1, idle_out});
    idle_out.blink = 1'b1;
    rows.push_back('{1, 1, 1, 32'd2000, 1, idle_out});
    rows.push_back('{0, 0, 1, 32'd2001, 0, '0});
    rows.push_back('{0, 1, 1, 32'd2002, 0, '0});
    rows.push_back('{1, 1, 1, 32'd2003, 0, '0});
    rows.push_back('{1, 1, 1, 32'd2007, 0, '0});
    rows.push_back('{1, 1, 0, 32'd2008, 0, '0});
    rows.push_back('{1, 1, 1, 32'd2013, 0, '0});
    rows.push_back('{1, 1, 1, 32'd2020, 0, '0});
    rows.push_back('{1, 1, 1, 32'd4000, 0, '0});
    rows.push_back('{1, 0, 1, 32'd4001, 0, '0});
    rows.push_back('{1, 1, 1, 32'd4006, 0, '0});
    rows.push_back('{0, 0, 0, 32'd4011, 0, '0});
    rows.push_back('{1, 1, 0, 32'd4016, 0, '0});
    rows.push_back('{1, 1, 1, 32'd4021, 0, '0});
    rows.push_back('{1, 1, 1, 32'hFFFF_FFFF, 0, '0});
    rows.push_back('{1, 1, 1, 32'd0, 0, '0});
    rows.push_back('{0, 1, 1, 32'd10, 0, '0});
    rows.push_back('{1, 1, 1, 32'd20, 0, '0});
    rows.push_back('{0, 1, 0, 32'd30, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_tick(row.left_n, row.right_n, row.stop_n, row.now_ms, row.typed, row.typed_out);
    end
    drain_ticks();

    // Random ramps across register settings, extremes included
    sup_set  = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd2, 3'd5};
    mpsc_set = '{16'hFFFF, 16'd0, 16'($urandom), 16'($urandom), 16'd1, 16'd0};
    lpsc_set = '{16'hFFFF, 16'd0, 16'($urandom), 16'd0, 16'($urandom), 16'd7};
    tnow     = 32'hFFFF_F000;
    item_idx = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(4'd0, 32'(sup_set[ph]));
      write_reg(4'd4, 32'(mpsc_set[ph]));
      write_reg(4'd8, 32'(lpsc_set[ph]));
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 200; k++) begin
        if (item_idx < 400) begin
          send_idle_pct = 24; recv_idle_pct = 78;
        end else if (item_idx < 800) begin
          send_idle_pct = 78; recv_idle_pct = 24;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        pick = $urandom_range(999);
        if (pick < 960) tnow = tnow + $urandom_range(6, 5);
        else if (pick < 990) tnow = tnow + $urandom_range(4);
        else tnow = tnow + $urandom_range(3000, 900);
        ln = 1'b1; rn = 1'b1; sn = 1'b1;
        pick = $urandom_range(999);
        if (pick < 6) ln = 1'b0;
        else if (pick < 12) rn = 1'b0;
        else if (pick < 15) sn = 1'b0;
        else if (pick < 25) {ln, rn, sn} = 3'($urandom_range(6));
        send_tick(ln, rn, sn, tnow, 1'b0, '0);
        item_idx++;
      end
      drain_ticks();
    end

    if (fail_cnt == 0 && pending_ticks.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
